### sv/atp_pkg.sv
// Shared constants, control word type and microcode table of the task placer.
// Used by the channel interfaces and by affinity_task_placer; no dependencies.
package atp_pkg;

    // Store sizes and field widths.
    localparam int NODES    = 64;
    localparam int ZONES    = 64;
    localparam int APPS     = 64;
    localparam int FIELD_W  = 7;
    localparam int LOAD_W   = 16;
    localparam int NODE_AW  = $clog2(NODES);
    localparam int ZONE_AW  = $clog2(ZONES);
    localparam int APP_IW   = $clog2(APPS);
    localparam int CFG_AW   = 3;
    localparam int STEP_W   = 3;

    // Operation codes.
    localparam logic OP_SET_ZONE = 1'b0;
    localparam logic OP_PLACE    = 1'b1;

    // Register indexes (word address bit above the byte offset).
    localparam logic REG_NODES_IN_USE = 1'b0;

    // Sequencer steps.
    localparam logic [STEP_W-1:0] ST_IDLE     = 3'd0;
    localparam logic [STEP_W-1:0] ST_DISPATCH = 3'd1;
    localparam logic [STEP_W-1:0] ST_SCAN     = 3'd2;
    localparam logic [STEP_W-1:0] ST_DECIDE   = 3'd3;
    localparam logic [STEP_W-1:0] ST_RD_NODE  = 3'd4;
    localparam logic [STEP_W-1:0] ST_RD_ZONE  = 3'd5;
    localparam logic [STEP_W-1:0] ST_WRITE    = 3'd6;
    localparam logic [STEP_W-1:0] ST_OUT      = 3'd7;

    // Jump conditions: when true, jump to the target, else go to the next step.
    localparam logic [2:0] C_NEXT        = 3'd0;
    localparam logic [2:0] C_NO_IN       = 3'd1;
    localparam logic [2:0] C_OP_ZONE     = 3'd2;
    localparam logic [2:0] C_SCAN_BUSY   = 3'd3;
    localparam logic [2:0] C_NONE_CHOSEN = 3'd4;
    localparam logic [2:0] C_OUT_BUSY    = 3'd5;

    // One control word of the program.
    typedef struct packed {
        logic [2:0]        cond;
        logic [STEP_W-1:0] target;
        logic              in_rdy;
        logic              clr;
        logic              wr_zone;
        logic              scan;
        logic              latch;
        logic              rd_node;
        logic              rd_zone;
        logic              wr_back;
        logic              load_out;
    } ucode_t;

    // Program ROM.
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        w = '0;
        case (step)
            ST_IDLE:
            begin
                w.in_rdy = 1'b1;
                w.cond   = C_NO_IN;
                w.target = ST_IDLE;
            end
            ST_DISPATCH:
            begin
                w.clr     = 1'b1;
                w.wr_zone = 1'b1;
                w.cond    = C_OP_ZONE;
                w.target  = ST_OUT;
            end
            ST_SCAN:
            begin
                w.scan   = 1'b1;
                w.cond   = C_SCAN_BUSY;
                w.target = ST_SCAN;
            end
            ST_DECIDE:
            begin
                w.latch  = 1'b1;
                w.cond   = C_NONE_CHOSEN;
                w.target = ST_OUT;
            end
            ST_RD_NODE:
            begin
                w.rd_node = 1'b1;
            end
            ST_RD_ZONE:
            begin
                w.rd_zone = 1'b1;
            end
            ST_WRITE:
            begin
                w.wr_back = 1'b1;
            end
            ST_OUT:
            begin
                w.load_out = 1'b1;
                w.cond     = C_OUT_BUSY;
                w.target   = ST_OUT;
            end
            default:
            begin
                w = '0;
            end
        endcase
        return w;
    endfunction

    // Application number in 1..APPS.
    function automatic logic app_ok(input logic [FIELD_W-1:0] a);
        return (a >= FIELD_W'(1)) && (a <= FIELD_W'(APPS));
    endfunction

    // Zone number in 1..ZONES.
    function automatic logic zone_ok(input logic [FIELD_W-1:0] z);
        return (z >= FIELD_W'(1)) && (z <= FIELD_W'(ZONES));
    endfunction

    // Bit position of an application number.
    function automatic logic [APP_IW-1:0] app_index(input logic [FIELD_W-1:0] a);
        logic [FIELD_W-1:0] d;
        d = a - FIELD_W'(1);
        return d[APP_IW-1:0];
    endfunction

    // Store address of a zone number.
    function automatic logic [ZONE_AW-1:0] zone_index(input logic [FIELD_W-1:0] z);
        logic [FIELD_W-1:0] d;
        d = z - FIELD_W'(1);
        return d[ZONE_AW-1:0];
    endfunction

    // Store address of a node number.
    function automatic logic [NODE_AW-1:0] node_index(input logic [FIELD_W-1:0] n);
        logic [FIELD_W-1:0] d;
        d = n - FIELD_W'(1);
        return d[NODE_AW-1:0];
    endfunction

endpackage

### sv/atp_task_if.sv
// Task channel: valid/ready handshake carrying one placer command.
// Depends on atp_pkg for the field width.
interface atp_task_if;
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic [atp_pkg::FIELD_W-1:0] node;
    logic [atp_pkg::FIELD_W-1:0] zone;
    logic [atp_pkg::FIELD_W-1:0] app;
    logic [atp_pkg::FIELD_W-1:0] want_zone;
    logic [atp_pkg::FIELD_W-1:0] want_app_zone;
    logic [atp_pkg::FIELD_W-1:0] avoid_app;
    logic                        strict;

    modport source (
        output valid, op, node, zone, app, want_zone, want_app_zone, avoid_app, strict,
        input  ready
    );
    modport sink (
        input  valid, op, node, zone, app, want_zone, want_app_zone, avoid_app, strict,
        output ready
    );
endinterface

### sv/atp_result_if.sv
// Result channel: valid/ready handshake carrying the chosen node.
// Depends on atp_pkg for the field width.
interface atp_result_if;
    logic                        valid;
    logic                        ready;
    logic [atp_pkg::FIELD_W-1:0] chosen_node;

    modport source (
        output valid, chosen_node,
        input  ready
    );
    modport sink (
        input  valid, chosen_node,
        output ready
    );
endinterface

### sv/affinity_task_placer.sv
// Affinity-aware least-loaded task placer, top level.
// Depends on atp_pkg, atp_task_if and atp_result_if.
//
// Usage: task_in carries one command per transfer. Op 0 sets the zone of a
//   node, op 1 places one task; every command gives exactly one transfer on
//   place_out (chosen_node, 0 when no node is taken or for op 0). The APB
//   port holds nodes_in_use at address 0; write it only while idle.
// Sequencing: a microcoded sequencer handles one command at a time. With
//   N = min(nodes_in_use, 64), the scan reads N nodes, one per cycle,
//   through a three-stage pipeline (node stores, zone store, compare), then
//   the chosen node is read again and written back. The result register
//   loads straight after dispatch for op 0, after the write back for op 1
//   and after the decision when no node is taken; the next command is
//   accepted once the sequencer is back in its idle step.
// Reset: all stores read as zero through per-entry valid bits, so no
//   clearing pass is needed; nodes_in_use returns to 64.
// Stall: the result waits in an output register while the next command is
//   accepted; the sequencer only waits if a second result is ready before
//   the first one is taken.
module affinity_task_placer (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [atp_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    atp_task_if.sink                   task_in,
    atp_result_if.source               place_out
);
    import atp_pkg::*;

    localparam int CNT_W = $clog2(NODES + 1);

    // Configuration and sequencer state.
    logic [FIELD_W-1:0] nodes_in_use_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  step_next;
    ucode_t             ucw;

    // Latched command.
    logic               op_reg;
    logic [FIELD_W-1:0] node_reg;
    logic [FIELD_W-1:0] zone_reg;
    logic [FIELD_W-1:0] app_reg;
    logic [FIELD_W-1:0] want_zone_reg;
    logic [FIELD_W-1:0] want_app_zone_reg;
    logic [FIELD_W-1:0] avoid_app_reg;
    logic               strict_reg;

    // Stores and their valid bits.
    logic [FIELD_W-1:0] node_zone_mem [NODES];
    logic [LOAD_W-1:0]  node_load_mem [NODES];
    logic [APPS-1:0]    node_apps_mem [NODES];
    logic [APPS-1:0]    zone_apps_mem [ZONES];
    logic [NODES-1:0]   node_zone_vld_reg;
    logic [NODES-1:0]   node_vld_reg;
    logic [ZONES-1:0]   zone_vld_reg;

    // Node store read port.
    logic               node_ren;
    logic [NODE_AW-1:0] node_raddr;
    logic [FIELD_W-1:0] rd_zone_reg;
    logic [LOAD_W-1:0]  rd_load_reg;
    logic [APPS-1:0]    rd_napps_reg;
    logic               rd_zone_v_reg;
    logic               rd_node_v_reg;
    logic [FIELD_W-1:0] rzone;
    logic [LOAD_W-1:0]  rload;
    logic [APPS-1:0]    rnapps;

    // Zone store read port.
    logic               zone_ren;
    logic [APPS-1:0]    zapps_reg;
    logic               zapps_ok_reg;
    logic [APPS-1:0]    zapps;

    // Scan pipeline.
    logic [CNT_W-1:0]   scan_idx_reg;
    logic [CNT_W-1:0]   scan_cnt;
    logic               scan_issue;
    logic               scan_busy;
    logic               s1_vld_reg;
    logic [NODE_AW-1:0] s1_idx_reg;
    logic               s2_vld_reg;
    logic [NODE_AW-1:0] s2_idx_reg;
    logic [FIELD_W-1:0] s2_zone_reg;
    logic [LOAD_W-1:0]  s2_load_reg;
    logic               s2_avoid_hit_reg;
    logic               elig;

    // Running best and best-without-avoided-app.
    logic               have_best_reg;
    logic [NODE_AW-1:0] best_idx_reg;
    logic [LOAD_W-1:0]  best_load_reg;
    logic               have_free_reg;
    logic [NODE_AW-1:0] free_idx_reg;
    logic [LOAD_W-1:0]  free_load_reg;

    // Choice and write back.
    logic [FIELD_W-1:0] chosen;
    logic [FIELD_W-1:0] chosen_reg;
    logic [NODE_AW-1:0] chosen_idx;
    logic [APPS-1:0]    app_bit;

    // Output register.
    logic               out_valid_reg;
    logic [FIELD_W-1:0] out_node_reg;
    logic               out_busy;
    logic               in_xfer;
    logic               cfg_wr;

    // APB register access.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_NODES_IN_USE) ? {25'd0, nodes_in_use_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nodes_in_use_reg <= FIELD_W'(NODES);
        end
        else if (cfg_wr && (paddr[2] == REG_NODES_IN_USE))
        begin
            nodes_in_use_reg <= pwdata[FIELD_W-1:0];
        end
    end

    // Microcode fetch and step sequencing.
    assign ucw      = ucode_rom(step_reg);
    assign in_xfer  = task_in.valid && ucw.in_rdy;
    assign out_busy = out_valid_reg && !place_out.ready;
    assign task_in.ready = ucw.in_rdy;

    always_comb
    begin
        logic jump;
        case (ucw.cond)
            C_NO_IN:       jump = !in_xfer;
            C_OP_ZONE:     jump = (op_reg == OP_SET_ZONE);
            C_SCAN_BUSY:   jump = scan_busy;
            C_NONE_CHOSEN: jump = (chosen == '0);
            C_OUT_BUSY:    jump = out_busy;
            default:       jump = 1'b0;
        endcase
        step_next = jump ? ucw.target : step_reg + STEP_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    // Command latch on an input transfer.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg            <= task_in.op;
            node_reg          <= task_in.node;
            zone_reg          <= task_in.zone;
            app_reg           <= task_in.app;
            want_zone_reg     <= task_in.want_zone;
            want_app_zone_reg <= task_in.want_app_zone;
            avoid_app_reg     <= task_in.avoid_app;
            strict_reg        <= task_in.strict;
        end
    end

    // Scan address counter; the scan covers min(nodes_in_use, NODES) nodes.
    assign scan_cnt   = (CNT_W'(nodes_in_use_reg) < CNT_W'(NODES)) ?
                        CNT_W'(nodes_in_use_reg) : CNT_W'(NODES);
    assign scan_issue = ucw.scan && (scan_idx_reg < scan_cnt);
    assign scan_busy  = scan_issue || s1_vld_reg || s2_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            s1_vld_reg   <= 1'b0;
            s2_vld_reg   <= 1'b0;
        end
        else
        begin
            if (ucw.clr)
            begin
                scan_idx_reg <= '0;
            end
            else if (scan_issue)
            begin
                scan_idx_reg <= scan_idx_reg + CNT_W'(1);
            end
            s1_vld_reg <= scan_issue;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    // Node store read, shared by the scan and the write-back read.
    assign chosen_idx = node_index(chosen_reg);
    assign node_ren   = scan_issue || ucw.rd_node;
    assign node_raddr = ucw.rd_node ? chosen_idx : scan_idx_reg[NODE_AW-1:0];

    always_ff @(posedge clk)
    begin
        if (node_ren)
        begin
            rd_zone_reg   <= node_zone_mem[node_raddr];
            rd_load_reg   <= node_load_mem[node_raddr];
            rd_napps_reg  <= node_apps_mem[node_raddr];
            rd_zone_v_reg <= node_zone_vld_reg[node_raddr];
            rd_node_v_reg <= node_vld_reg[node_raddr];
        end
        if (scan_issue)
        begin
            s1_idx_reg <= scan_idx_reg[NODE_AW-1:0];
        end
    end

    // Entries never written read as zero.
    assign rzone  = rd_zone_v_reg ? rd_zone_reg : '0;
    assign rload  = rd_node_v_reg ? rd_load_reg : '0;
    assign rnapps = rd_node_v_reg ? rd_napps_reg : '0;

    // Zone store read at the zone of the node just read.
    assign zone_ren = s1_vld_reg || ucw.rd_zone;

    always_ff @(posedge clk)
    begin
        if (zone_ren)
        begin
            zapps_reg    <= zone_apps_mem[zone_index(rzone)];
            zapps_ok_reg <= zone_ok(rzone) && zone_vld_reg[zone_index(rzone)];
        end
        if (s1_vld_reg)
        begin
            s2_idx_reg       <= s1_idx_reg;
            s2_zone_reg      <= rzone;
            s2_load_reg      <= rload;
            s2_avoid_hit_reg <= app_ok(avoid_app_reg) && rnapps[app_index(avoid_app_reg)];
        end
    end

    assign zapps = zapps_ok_reg ? zapps_reg : '0;

    // Eligibility of the node in the last scan stage.
    assign elig = ((want_zone_reg == '0) || (s2_zone_reg == want_zone_reg)) &&
                  ((want_app_zone_reg == '0) ||
                   (zone_ok(s2_zone_reg) && app_ok(want_app_zone_reg) &&
                    zapps[app_index(want_app_zone_reg)]));

    // Least-load trackers; strict compare keeps the lowest index on ties.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_best_reg <= 1'b0;
            have_free_reg <= 1'b0;
        end
        else if (ucw.clr)
        begin
            have_best_reg <= 1'b0;
            have_free_reg <= 1'b0;
        end
        else if (s2_vld_reg && elig)
        begin
            if (!have_best_reg || (s2_load_reg < best_load_reg))
            begin
                have_best_reg <= 1'b1;
            end
            if ((avoid_app_reg != '0) && !s2_avoid_hit_reg &&
                (!have_free_reg || (s2_load_reg < free_load_reg)))
            begin
                have_free_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_vld_reg && elig)
        begin
            if (!have_best_reg || (s2_load_reg < best_load_reg))
            begin
                best_idx_reg  <= s2_idx_reg;
                best_load_reg <= s2_load_reg;
            end
            if ((avoid_app_reg != '0) && !s2_avoid_hit_reg &&
                (!have_free_reg || (s2_load_reg < free_load_reg)))
            begin
                free_idx_reg  <= s2_idx_reg;
                free_load_reg <= s2_load_reg;
            end
        end
    end

    // Final choice after the scan.
    always_comb
    begin
        chosen = '0;
        if (have_best_reg)
        begin
            if (avoid_app_reg == '0)
            begin
                chosen = FIELD_W'(best_idx_reg) + FIELD_W'(1);
            end
            else if (have_free_reg)
            begin
                chosen = FIELD_W'(free_idx_reg) + FIELD_W'(1);
            end
            else if (!strict_reg)
            begin
                chosen = FIELD_W'(best_idx_reg) + FIELD_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chosen_reg <= '0;
        end
        else if (ucw.clr)
        begin
            chosen_reg <= '0;
        end
        else if (ucw.latch)
        begin
            chosen_reg <= chosen;
        end
    end

    // Store writes: zone setting and placement write back.
    assign app_bit = app_ok(app_reg) ? (APPS'(1) << app_index(app_reg)) : '0;

    always_ff @(posedge clk)
    begin
        if (ucw.wr_zone && (op_reg == OP_SET_ZONE) &&
            (node_reg >= FIELD_W'(1)) && (node_reg <= FIELD_W'(NODES)))
        begin
            node_zone_mem[node_index(node_reg)] <= zone_reg;
        end
        if (ucw.wr_back)
        begin
            node_load_mem[chosen_idx] <= (rload == '1) ? rload : rload + LOAD_W'(1);
            node_apps_mem[chosen_idx] <= rnapps | app_bit;
            if (zone_ok(rzone))
            begin
                zone_apps_mem[zone_index(rzone)] <= zapps | app_bit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_zone_vld_reg <= '0;
            node_vld_reg      <= '0;
            zone_vld_reg      <= '0;
        end
        else
        begin
            if (ucw.wr_zone && (op_reg == OP_SET_ZONE) &&
                (node_reg >= FIELD_W'(1)) && (node_reg <= FIELD_W'(NODES)))
            begin
                node_zone_vld_reg[node_index(node_reg)] <= 1'b1;
            end
            if (ucw.wr_back)
            begin
                node_vld_reg[chosen_idx] <= 1'b1;
                if (zone_ok(rzone))
                begin
                    zone_vld_reg[zone_index(rzone)] <= 1'b1;
                end
            end
        end
    end

    // Output register; a transfer empties it unless a new result loads.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ucw.load_out && !out_busy)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (place_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ucw.load_out && !out_busy)
        begin
            out_node_reg <= chosen_reg;
        end
    end

    assign place_out.valid       = out_valid_reg;
    assign place_out.chosen_node = out_node_reg;

endmodule
